// ----- rtl/core/dcpc_pkg.sv -----
`default_nettype none

package dcpc_pkg;

    localparam int CHANNEL_W        = 8;
    localparam int COUNT_W          = 21;
    localparam int PIXEL_TDATA_W    = 24;
    localparam int RESULT_TDATA_W   = 72;
    localparam int MAX_FRAME_PIXELS = 1048576;

    localparam logic [COUNT_W-1:0] COUNT_MASK = {COUNT_W{1'b1}};

    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_FRAME_PIXELS > 2097151) ? COUNT_MASK : COUNT_W'(MAX_FRAME_PIXELS);

    localparam logic [CHANNEL_W-1:0] THRESHOLD_RESET = 8'd80;

    typedef enum logic [1:0] {
        DOM_NONE  = 2'd0,
        DOM_RED   = 2'd1,
        DOM_GREEN = 2'd2,
        DOM_BLUE  = 2'd3
    } dominant_t;

    function automatic logic is_color(
        input logic [CHANNEL_W-1:0] main_ch,
        input logic [CHANNEL_W-1:0] other_a,
        input logic [CHANNEL_W-1:0] other_b,
        input logic [CHANNEL_W-1:0] threshold
    );
        logic [CHANNEL_W:0] main_x;
        logic [CHANNEL_W:0] dbl_a;
        logic [CHANNEL_W:0] dbl_b;
        main_x = {1'b0, main_ch};
        dbl_a  = {other_a, 1'b0};
        dbl_b  = {other_b, 1'b0};
        return (main_ch > threshold) && (main_x > dbl_a) && (main_x > dbl_b);
    endfunction

    function automatic logic [COUNT_W-1:0] bump(
        input logic [COUNT_W-1:0] count,
        input logic               hit
    );
        logic [COUNT_W-1:0] result;
        result = count;
        if (hit && (count < COUNT_LIMIT))
        begin
            result = count + COUNT_W'(1);
        end
        else if (hit)
        begin
            result = COUNT_LIMIT;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dominant_color_pixel_counter_unit.sv -----
// The pixel with tlast passes the input register, then the result register drives m_axis.
// Throughput: one pixel per cycle unless the stall below holds; classification and
// counter update sit between the input register and the result register.
// A result waiting on m_axis stalls the input only when the next frame-end pixel arrives.
// Reset (rst_n low, asynchronous): counters cleared, threshold back to 80, both sides empty.
`default_nettype none

module dominant_color_pixel_counter_unit
    import dcpc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CHANNEL_W-1:0]      cfg_wr_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [PIXEL_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                      s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // red_count [20:0], green_count [41:21], blue_count [62:42], dominant [64:63], zero pad
    output logic [RESULT_TDATA_W-1:0]      m_axis_tdata
);

    logic [CHANNEL_W-1:0] threshold_reg;

    logic                 in_valid_reg;
    logic                 in_last_reg;
    logic [CHANNEL_W-1:0] red_reg;
    logic [CHANNEL_W-1:0] green_reg;
    logic [CHANNEL_W-1:0] blue_reg;

    logic [COUNT_W-1:0]   red_total_reg;
    logic [COUNT_W-1:0]   green_total_reg;
    logic [COUNT_W-1:0]   blue_total_reg;

    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   red_count_reg;
    logic [COUNT_W-1:0]   green_count_reg;
    logic [COUNT_W-1:0]   blue_count_reg;
    dominant_t            dominant_reg;

    logic                 advance;
    logic                 out_free;
    logic [COUNT_W-1:0]   red_total_next;
    logic [COUNT_W-1:0]   green_total_next;
    logic [COUNT_W-1:0]   blue_total_next;
    dominant_t            dominant_next;
    logic [COUNT_W-1:0]   best;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        red_total_next   = bump(red_total_reg,
                                is_color(red_reg, green_reg, blue_reg, threshold_reg));
        green_total_next = bump(green_total_reg,
                                is_color(green_reg, red_reg, blue_reg, threshold_reg));
        blue_total_next  = bump(blue_total_reg,
                                is_color(blue_reg, red_reg, green_reg, threshold_reg));

        best          = '0;
        dominant_next = DOM_NONE;
        if (red_total_next > best)
        begin
            best          = red_total_next;
            dominant_next = DOM_RED;
        end
        if (green_total_next > best)
        begin
            best          = green_total_next;
            dominant_next = DOM_GREEN;
        end
        if (blue_total_next > best)
        begin
            dominant_next = DOM_BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            red_reg     <= s_axis_tdata[7:0];
            green_reg   <= s_axis_tdata[15:8];
            blue_reg    <= s_axis_tdata[23:16];
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_total_reg   <= '0;
            green_total_reg <= '0;
            blue_total_reg  <= '0;
        end
        else if (advance && in_last_reg)
        begin
            red_total_reg   <= '0;
            green_total_reg <= '0;
            blue_total_reg  <= '0;
        end
        else if (advance)
        begin
            red_total_reg   <= red_total_next;
            green_total_reg <= green_total_next;
            blue_total_reg  <= blue_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            red_count_reg   <= red_total_next;
            green_count_reg <= green_total_next;
            blue_count_reg  <= blue_total_next;
            dominant_reg    <= dominant_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, dominant_reg, blue_count_reg, green_count_reg,
                            red_count_reg};

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        red_total_reg <= COUNT_LIMIT && green_total_reg <= COUNT_LIMIT &&
        blue_total_reg <= COUNT_LIMIT)
        else $error("pixel counter above limit");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> red_total_reg == '0 && green_total_reg == '0 &&
        blue_total_reg == '0)
        else $error("counters not cleared after frame end");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dominant_reg == DOM_NONE |->
        red_count_reg == '0 && green_count_reg == '0 && blue_count_reg == '0)
        else $error("dominant none with nonzero count");

    a_red_wins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dominant_reg == DOM_RED |->
        red_count_reg >= green_count_reg && red_count_reg >= blue_count_reg)
        else $error("dominant red with smaller red count");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |-> !out_valid_reg || m_axis_tready)
        else $error("result register overwritten");

endmodule

`default_nettype wire
